@@ rtl/midi_binding_matcher_assert.svh @@
// assertion macros for the midi binding matcher, used by mbm_ctrl
// expects clk and rst to be visible in the module that uses them
`ifndef MIDI_BINDING_MATCHER_ASSERT_SVH
`define MIDI_BINDING_MATCHER_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define MBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define MBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbm_pkg.sv @@
// types, codes and constants of the midi binding matcher
// no dependencies; imported by every rtl module of the block
package mbm_pkg;

  typedef enum logic [2:0] {
    OP_MIDI        = 3'd0,
    OP_WRITE       = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_LEARN_START = 3'd3,
    OP_LEARN_STOP  = 3'd4,
    OP_TICK        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_CC       = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_TOGGLE    = 2'd0,
    MODE_MOMENTARY = 2'd1,
    MODE_CONTINUOUS = 2'd2,
    MODE_NOTE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RES_ACTION     = 2'd0,
    RES_LEARN_CC   = 2'd1,
    RES_LEARN_NOTE = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_SETVOL  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_LEARN
  } state_t;

  localparam int Threshold  = 64;
  localparam int MaxResults = 16;
  localparam int ResCntW    = $clog2(MaxResults + 1);
  localparam int TimeoutW   = 20;
  localparam int CfgW       = 20;
  localparam logic [TimeoutW-1:0] TimeoutReset = 20'd30000;
  localparam logic [7:0] GainReset   = 8'd1;
  localparam logic [7:0] SetVolReset = 8'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] number;
    logic [4:0] channel;
    logic [7:0] device;
    logic [7:0] action;
  } entry_t;

  // table update strobes for one cycle
  typedef struct packed {
    logic write;
    logic remove;
    logic tog_we;
    logic tog_val;
  } tbl_ctl_t;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout;
    logic [7:0]          gain_code;
    logic [7:0]          setvol_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  action;
    logic [15:0] param;
    logic        pvalid;
    logic        target;
    logic [6:0]  lnum;
    logic [4:0]  lch;
    logic [7:0]  ldev;
  } res_t;

  // round(v*16384/127), halves up: 16384 = 127*129 + 1
  function automatic logic [15:0] scale_unit(input logic [6:0] v);
    logic [15:0] base;
    base = {2'b00, v, 7'b0} + {9'b0, v};
    return base + {15'b0, v[6]};
  endfunction

  // round(v*32768/127), halves up: 32768 = 127*258 + 2
  function automatic logic [15:0] scale_gain(input logic [6:0] v);
    logic [15:0] base;
    logic [1:0]  rnd;
    base = {1'b0, v, 8'b0} + {8'b0, v, 1'b0};
    rnd  = (v >= 7'd96) ? 2'd2 : ((v >= 7'd32) ? 2'd1 : 2'd0);
    return base + {14'b0, rnd};
  endfunction

endpackage

@@ rtl/mbm_table.sv @@
// binding table: entry memory with registered read, valid and toggle flops
// depends on mbm_pkg
module mbm_table import mbm_pkg::*; #(
  parameter int MAX_BINDINGS = 16,
  localparam int AddrW = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tbl_ctl_t             ctl,
  input  logic [AddrW-1:0]     waddr,
  input  entry_t               wentry,
  input  logic [AddrW-1:0]     taddr,
  input  logic [AddrW-1:0]     raddr,
  output entry_t               rd_entry,
  output logic                 rd_valid,
  output logic                 rd_toggle
);

  entry_t                  mem [MAX_BINDINGS];
  logic [MAX_BINDINGS-1:0] valid;
  logic [MAX_BINDINGS-1:0] toggle;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[waddr] <= wentry;
    end
    rd_entry  <= mem[raddr];
    rd_valid  <= valid[raddr];
    rd_toggle <= toggle[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      toggle <= '0;
    end else begin
      if (ctl.write) begin
        valid[waddr]  <= 1'b1;
        toggle[waddr] <= 1'b0;
      end else if (ctl.remove) begin
        valid[waddr] <= 1'b0;
      end
      if (ctl.tog_we) begin
        toggle[taddr] <= ctl.tog_val;
      end
    end
  end

endmodule

@@ rtl/mbm_ctrl.sv @@
// sequencer: op decode, learn mode, table walk through one shared match unit
// depends on mbm_pkg, mbm_table and midi_binding_matcher_assert.svh
`include "midi_binding_matcher_assert.svh"

module mbm_ctrl import mbm_pkg::*; #(
  parameter int MAX_BINDINGS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [1:0] msg_kind,
  input  logic [6:0] number,
  input  logic [4:0] channel,
  input  logic [6:0] value,
  input  logic [7:0] device_id,
  input  logic [3:0] entry_index,
  input  logic [1:0] bind_mode,
  input  logic [7:0] action_code,
  output logic       out_vld,
  output res_t       out_res,
  output logic       out_last
);
  localparam int AddrW = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(MAX_BINDINGS - 1);

  state_t st, st_next;

  logic accept, in_range, is_msg;
  logic [1:0] q_kind;
  logic [6:0] q_num;
  logic [4:0] q_ch;
  logic [6:0] q_val;
  logic [7:0] q_dev;

  logic                learning;
  logic [TimeoutW-1:0] ticks;
  logic [TimeoutW-1:0] ticks_inc;

  logic [AddrW-1:0]   cnt;
  logic [ResCntW-1:0] res_cnt;
  logic               held_vld;
  res_t               held;

  tbl_ctl_t         ctl;
  logic [AddrW-1:0] raddr;
  entry_t           ent;
  logic             ent_valid, ent_toggle;

  logic hit, fire, take, is_cc, over, is_cont, is_gain;
  logic emit;
  res_t cand;
  res_t learn_res;

  assign accept    = start && !busy;
  assign in_range  = 32'(entry_index) < MAX_BINDINGS;
  assign is_msg    = (msg_kind == KIND_CC) || (msg_kind == KIND_NOTE_ON);
  assign ticks_inc = ticks + 1'b1;

  mbm_table #(.MAX_BINDINGS(MAX_BINDINGS)) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .waddr    (AddrW'(entry_index)),
    .wentry   ({bind_mode, number, channel, device_id, action_code}),
    .taddr    (cnt),
    .raddr    (raddr),
    .rd_entry (ent),
    .rd_valid (ent_valid),
    .rd_toggle(ent_toggle)
  );

  // shared match unit, one entry per cycle
  always_comb begin
    is_cc   = q_kind == KIND_CC;
    over    = q_val >= 7'(Threshold);
    is_cont = ent.mode == MODE_CONTINUOUS;
    is_gain = ent.action == cfg.gain_code;
    hit = ent_valid && (ent.number == q_num)
       && ((ent.channel == 5'd0) || (ent.channel == q_ch))
       && ((ent.device == 8'd0) || (ent.device == q_dev));
    fire = 1'b0;
    if (!is_cc) begin
      fire = ent.mode == MODE_NOTE;
    end else begin
      unique case (ent.mode)
        MODE_TOGGLE:     fire = over && !ent_toggle;
        MODE_MOMENTARY:  fire = over;
        MODE_CONTINUOUS: fire = 1'b1;
        MODE_NOTE:       fire = 1'b0;
      endcase
    end
    take = (st == ST_SCAN) && hit && fire && (res_cnt < ResCntW'(MaxResults));
    cand        = '0;
    cand.kind   = RES_ACTION;
    cand.action = (is_cc && is_cont && is_gain) ? cfg.setvol_code : ent.action;
    cand.pvalid = is_cc && is_cont;
    cand.target = is_cc && is_cont && is_gain;
    if (is_cc && is_cont) begin
      cand.param = is_gain ? scale_gain(q_val) : scale_unit(q_val);
    end
  end

  // captured message while learning
  always_comb begin
    learn_res      = '0;
    learn_res.kind = (q_kind == KIND_CC) ? RES_LEARN_CC : RES_LEARN_NOTE;
    learn_res.lnum = q_num;
    learn_res.lch  = q_ch;
    learn_res.ldev = q_dev;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (accept && (op == OP_MIDI) && is_msg) begin
          st_next = learning ? ST_LEARN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == LastIdx) begin
          st_next = ST_DONE;
        end
      end
      ST_DONE:  st_next = ST_IDLE;
      ST_LEARN: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = st != ST_IDLE;
    ctl   = '0;
    raddr = '0;
    emit  = 1'b0;
    unique case (st)
      ST_IDLE: begin
        ctl.write  = accept && (op == OP_WRITE) && in_range;
        ctl.remove = accept && (op == OP_REMOVE) && in_range;
      end
      ST_SCAN: begin
        raddr       = (cnt == LastIdx) ? '0 : cnt + 1'b1;
        ctl.tog_we  = hit && is_cc && (ent.mode == MODE_TOGGLE);
        ctl.tog_val = over;
        emit        = take && held_vld;
      end
      ST_DONE:  emit = held_vld;
      ST_LEARN: emit = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      out_vld  <= 1'b0;
      held_vld <= 1'b0;
      learning <= 1'b0;
      ticks    <= '0;
      res_cnt  <= '0;
      cnt      <= '0;
    end else begin
      st      <= st_next;
      out_vld <= emit;
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            q_kind   <= msg_kind;
            q_num    <= number;
            q_ch     <= channel;
            q_val    <= value;
            q_dev    <= device_id;
            cnt      <= '0;
            res_cnt  <= '0;
            held_vld <= 1'b0;
            case (op)
              OP_MIDI: begin
                if (is_msg) begin
                  learning <= 1'b0;
                end
              end
              OP_LEARN_START: begin
                learning <= 1'b1;
                ticks    <= '0;
              end
              OP_LEARN_STOP: learning <= 1'b0;
              OP_TICK: begin
                if (learning) begin
                  ticks <= ticks_inc;
                  if (ticks_inc >= cfg.timeout) begin
                    learning <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (take) begin
            res_cnt  <= res_cnt + 1'b1;
            held     <= cand;
            held_vld <= 1'b1;
            if (held_vld) begin
              out_res  <= held;
              out_last <= 1'b0;
            end
          end
        end
        ST_DONE: begin
          if (held_vld) begin
            out_res  <= held;
            out_last <= 1'b1;
          end
          held_vld <= 1'b0;
        end
        ST_LEARN: begin
          out_res  <= learn_res;
          out_last <= 1'b1;
        end
      endcase
    end
  end

  `MBM_ASSERT_IMP(a_out_src, out_vld,
    $past(st == ST_SCAN) || $past(st == ST_DONE) || $past(st == ST_LEARN),
    "result strobe without a scan or learn step")
  `MBM_ASSERT_IMP(a_idle_empty, st == ST_IDLE, !held_vld,
    "held result left over in idle")
  `MBM_ASSERT_IMP(a_res_cap, 1'b1, res_cnt <= ResCntW'(MaxResults),
    "result count beyond cap")
  `MBM_ASSERT_NXT(a_learn_cap,
    accept && (op == OP_MIDI) && is_msg && learning,
    (st == ST_LEARN) && !learning,
    "learn capture did not end learn mode")

endmodule

@@ rtl/midi_binding_matcher.sv @@
// top level of the midi binding matcher: config registers and result ports
// depends on mbm_pkg and mbm_ctrl
// - command port: an item transfers at a rising edge with start high and
//   busy low; op selects midi message, write/remove binding, start/stop
//   learn or tick
// - table ops, learn ops, ticks and ignored messages (note-off, unknown
//   kind or op) complete at the accepting edge; busy stays low
// - a control change or note-on walks the table one entry per cycle through
//   the single read port of the entry memory; busy stays high through the
//   scan and a final done step, so a new message is taken only after both
// - results leave at most one per cycle on result_valid, in entry order, each
//   held in a register until the next hit or the done step; last marks the
//   final result of the item; at most sixteen results per item
// - while learning, a control change or note-on gives a single learn result
//   through the learn state, is busy while in it and ends learn mode
// - the receiver cannot stall: every result is shown for one cycle only
// - config writes take effect at once and are meant for idle periods
// - rst clears valid bits, toggle state, learn state and config defaults;
//   entry contents stay undefined until written
module midi_binding_matcher import mbm_pkg::*; #(
  parameter int MAX_BINDINGS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      op,
  input  logic [1:0]      msg_kind,
  input  logic [6:0]      number,
  input  logic [4:0]      channel,
  input  logic [6:0]      value,
  input  logic [7:0]      device_id,
  input  logic [3:0]      entry_index,
  input  logic [1:0]      bind_mode,
  input  logic [7:0]      action_code,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [CfgW-1:0] cfg_wdata,
  output logic            result_valid,
  output logic [1:0]      result_kind,
  output logic [7:0]      out_action,
  output logic [15:0]     param_value,
  output logic            param_valid,
  output logic            target_input,
  output logic [6:0]      learned_number,
  output logic [4:0]      learned_channel,
  output logic [7:0]      learned_device,
  output logic            last
);

  cfg_t cfg;
  res_t res;

  // config registers, written any time the port strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout     <= TimeoutReset;
      cfg.gain_code   <= GainReset;
      cfg.setvol_code <= SetVolReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT: cfg.timeout     <= cfg_wdata[TimeoutW-1:0];
        CFG_GAIN:    cfg.gain_code   <= cfg_wdata[7:0];
        CFG_SETVOL:  cfg.setvol_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer plus table; results come out registered
  mbm_ctrl #(.MAX_BINDINGS(MAX_BINDINGS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .msg_kind   (msg_kind),
    .number     (number),
    .channel    (channel),
    .value      (value),
    .device_id  (device_id),
    .entry_index(entry_index),
    .bind_mode  (bind_mode),
    .action_code(action_code),
    .out_vld    (result_valid),
    .out_res    (res),
    .out_last   (last)
  );

  // unpack the result register onto the field ports
  assign result_kind     = res.kind;
  assign out_action      = res.action;
  assign param_value     = res.param;
  assign param_valid     = res.pvalid;
  assign target_input    = res.target;
  assign learned_number  = res.lnum;
  assign learned_channel = res.lch;
  assign learned_device  = res.ldev;

endmodule

@@ tb/sv/midi_binding_matcher_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for midi_binding_matcher: directed and random commands
// depends on mbm_pkg and the midi_binding_matcher rtl; needs no other files
module midi_binding_matcher_test import mbm_pkg::*;;

  localparam int NumEntries = 16;
  localparam int WatchdogLimit = 2000;
  // margin for busy to drop after a scanned message, so this covers the tail
  localparam int SettleCycles = 24;
  localparam int PhaseCommands = 68;
  localparam int NumPhases = 5;

  // op and kind codes the block must ignore
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam logic [1:0] KindSpare = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] kind;
    logic [6:0] number;
    logic [4:0] channel;
    logic [6:0] value;
    logic [7:0] device;
    logic [3:0] index;
    logic [1:0] mode;
    logic [7:0] action;
  } command_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  action;
    logic [15:0] param;
    logic        pvalid;
    logic        target;
    logic [6:0]  lnum;
    logic [4:0]  lch;
    logic [7:0]  ldev;
    logic        last;
  } outcome_t;

  // binding table mirror plus the queue of outcomes still owed by the block
  class binding_scoreboard;
    logic [19:0] timeout_ticks;
    logic [7:0]  gain_code;
    logic [7:0]  setvol_code;
    logic        bound     [NumEntries];
    logic [1:0]  b_mode    [NumEntries];
    logic [6:0]  b_number  [NumEntries];
    logic [4:0]  b_channel [NumEntries];
    logic [7:0]  b_device  [NumEntries];
    logic [7:0]  b_action  [NumEntries];
    logic        toggled   [NumEntries];
    logic        learning;
    logic [19:0] ticks;
    outcome_t    pending [$];
    int          failures;
    int          checked;
    int          captures;
    int          full_hits;

    function new();
      timeout_ticks = TimeoutReset;
      gain_code = GainReset;
      setvol_code = SetVolReset;
      foreach (bound[i]) begin
        bound[i] = 1'b0;
        toggled[i] = 1'b0;
      end
      learning = 1'b0;
      ticks = '0;
      failures = 0;
      checked = 0;
      captures = 0;
      full_hits = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [19:0] data);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = data;
        CFG_GAIN:    gain_code = data[7:0];
        CFG_SETVOL:  setvol_code = data[7:0];
        default: ;
      endcase
    endfunction

    // append one owed outcome at the tail of the queue
    function void owe(outcome_t r);
      pending = {pending, r};
    endfunction

    // work out what one accepted command leaves behind
    function void note_command(command_t c);
      outcome_t    r;
      outcome_t    held;
      bit          have;
      bit          fire;
      bit          hot;
      int          n;
      int          i;
      int unsigned scaled;
      have = 1'b0;
      n = 0;
      held = '0;
      case (c.op)
        OP_WRITE: begin
          bound[c.index] = 1'b1;
          b_mode[c.index] = c.mode;
          b_number[c.index] = c.number;
          b_channel[c.index] = c.channel;
          b_device[c.index] = c.device;
          b_action[c.index] = c.action;
          toggled[c.index] = 1'b0;
        end
        OP_REMOVE: bound[c.index] = 1'b0;
        OP_LEARN_START: begin
          learning = 1'b1;
          ticks = '0;
        end
        OP_LEARN_STOP: learning = 1'b0;
        OP_TICK: begin
          if (learning) begin
            ticks = ticks + 20'd1;
            if (ticks >= timeout_ticks) learning = 1'b0;
          end
        end
        OP_MIDI: begin
          if (c.kind == KIND_CC || c.kind == KIND_NOTE_ON) begin
            if (learning) begin
              learning = 1'b0;
              r = '0;
              r.kind = (c.kind == KIND_CC) ? RES_LEARN_CC : RES_LEARN_NOTE;
              r.lnum = c.number;
              r.lch = c.channel;
              r.ldev = c.device;
              r.last = 1'b1;
              owe(r);
              captures++;
            end else begin
              for (i = 0; i < NumEntries; i++) begin
                if (bound[i] && b_number[i] == c.number &&
                    (b_channel[i] == 5'd0 || b_channel[i] == c.channel) &&
                    (b_device[i] == 8'd0 || b_device[i] == c.device)) begin
                  r = '0;
                  r.kind = RES_ACTION;
                  r.action = b_action[i];
                  fire = 1'b0;
                  if (c.kind == KIND_NOTE_ON) begin
                    fire = (b_mode[i] == MODE_NOTE);
                  end else begin
                    case (b_mode[i])
                      MODE_TOGGLE: begin
                        hot = (c.value >= Threshold);
                        if (hot != toggled[i]) begin
                          toggled[i] = hot;
                          fire = hot;
                        end
                      end
                      MODE_MOMENTARY: fire = (c.value >= Threshold);
                      MODE_CONTINUOUS: begin
                        fire = 1'b1;
                        r.pvalid = 1'b1;
                        if (b_action[i] == gain_code) begin
                          r.action = setvol_code;
                          r.target = 1'b1;
                          scaled = (int'(c.value) * 32768 + 63) / 127;
                        end else begin
                          scaled = (int'(c.value) * 16384 + 63) / 127;
                        end
                        r.param = 16'(scaled);
                      end
                      default: ;
                    endcase
                  end
                  // beyond the result cap the toggle state still moves
                  if (fire && n < MaxResults) begin
                    if (have) owe(held);
                    held = r;
                    have = 1'b1;
                    n++;
                  end
                end
              end
              if (have) begin
                held.last = 1'b1;
                owe(held);
                if (n == MaxResults) full_hits++;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        failures++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: kind %0d action %0d", got.kind, got.action);
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare("result_kind", 16'(want.kind), 16'(got.kind));
      compare("out_action", 16'(want.action), 16'(got.action));
      compare("param_value", want.param, got.param);
      compare("param_valid", 16'(want.pvalid), 16'(got.pvalid));
      compare("target_input", 16'(want.target), 16'(got.target));
      compare("learned_number", 16'(want.lnum), 16'(got.lnum));
      compare("learned_channel", 16'(want.lch), 16'(got.lch));
      compare("learned_device", 16'(want.ldev), 16'(got.ldev));
      compare("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [2:0]      op;
  logic [1:0]      msg_kind;
  logic [6:0]      number;
  logic [4:0]      channel;
  logic [6:0]      value;
  logic [7:0]      device_id;
  logic [3:0]      entry_index;
  logic [1:0]      bind_mode;
  logic [7:0]      action_code;
  logic            cfg_we;
  logic [1:0]      cfg_addr;
  logic [CfgW-1:0] cfg_wdata;
  logic            result_valid;
  logic [1:0]      result_kind;
  logic [7:0]      out_action;
  logic [15:0]     param_value;
  logic            param_valid;
  logic            target_input;
  logic [6:0]      learned_number;
  logic [4:0]      learned_channel;
  logic [7:0]      learned_device;
  logic            last;

  binding_scoreboard board = new();
  int commands_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  outcome_t observed;

  midi_binding_matcher dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .msg_kind(msg_kind), .number(number), .channel(channel),
    .value(value), .device_id(device_id), .entry_index(entry_index),
    .bind_mode(bind_mode), .action_code(action_code),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .result_kind(result_kind),
    .out_action(out_action), .param_value(param_value),
    .param_valid(param_valid), .target_input(target_input),
    .learned_number(learned_number), .learned_channel(learned_channel),
    .learned_device(learned_device), .last(last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // results are strobed for a single cycle; pick them up at the closing edge
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      observed.kind = result_kind;
      observed.action = out_action;
      observed.param = param_value;
      observed.pvalid = param_valid;
      observed.target = target_input;
      observed.lnum = learned_number;
      observed.lch = learned_channel;
      observed.ldev = learned_device;
      observed.last = last;
      board.check_result(observed);
    end
  end

  // stall detector: any command transfer or result counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("midi_binding_matcher_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic command_t mk(logic [2:0] o, logic [1:0] k, logic [6:0] num,
                                  logic [4:0] ch, logic [6:0] val, logic [7:0] dev,
                                  logic [3:0] idx, logic [1:0] md, logic [7:0] act);
    command_t c;
    c.op = o;
    c.kind = k;
    c.number = num;
    c.channel = ch;
    c.value = val;
    c.device = dev;
    c.index = idx;
    c.mode = md;
    c.action = act;
    return c;
  endfunction

  // every field random over its full width; callers override what matters
  function automatic command_t scrambled(logic [2:0] o);
    command_t c;
    c = command_t'({$urandom, $urandom});
    c.op = o;
    return c;
  endfunction

  // small pools so that messages keep hitting the stored bindings
  function automatic logic [6:0] pick_number();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd5;
      2: return 7'd64;
      3: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [6:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd63;
      2: return 7'd64;
      3: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [4:0] pick_msg_channel();
    case ($urandom_range(0, 9))
      0: return 5'd1;
      1: return 5'd16;
      2: return 5'($urandom_range(0, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [4:0] pick_bind_channel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 5'd0;
      4: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [7:0] pick_device();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'd0;
      3: return 8'd1;
      4: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_action();
    if ($urandom_range(0, 2) == 0) return board.gain_code;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic command_t message(logic [1:0] k);
    command_t c;
    c = scrambled(OP_MIDI);
    c.kind = k;
    c.number = pick_number();
    c.channel = pick_msg_channel();
    c.value = pick_value();
    c.device = pick_device();
    return c;
  endfunction

  function automatic command_t binding(logic [3:0] idx, logic [1:0] md, logic [6:0] num);
    command_t c;
    c = scrambled(OP_WRITE);
    c.index = idx;
    c.mode = md;
    c.number = num;
    c.channel = pick_bind_channel();
    c.device = pick_device();
    c.action = pick_action();
    return c;
  endfunction

  // one command transfer: optional gap, then hold start until busy is low
  task automatic send_command(input command_t c);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(8, 24);
    end
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start <= 1'b1;
    op <= c.op;
    msg_kind <= c.kind;
    number <= c.number;
    channel <= c.channel;
    value <= c.value;
    device_id <= c.device;
    entry_index <= c.index;
    bind_mode <= c.mode;
    action_code <= c.action;
    do @(posedge clk); while (busy);
    // spare ops and unmatched message kinds do not count toward the goal
    if (c.op <= OP_TICK && !(c.op == OP_MIDI && (c.kind == KIND_NOTE_OFF || c.kind == KindSpare)))
      commands_sent++;
    board.note_command(c);
  endtask

  // let every outstanding result come back, then give the scan time to finish
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_registers(input logic [19:0] t, input logic [7:0] g, input logic [7:0] s);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_TIMEOUT;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_addr <= CFG_GAIN;
    cfg_wdata <= {12'd0, g};
    @(negedge clk);
    cfg_addr <= CFG_SETVOL;
    cfg_wdata <= {12'd0, s};
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(CFG_TIMEOUT, t);
    board.set_register(CFG_GAIN, {12'd0, g});
    board.set_register(CFG_SETVOL, {12'd0, s});
  endtask

  task automatic directed_part();
    // a small table covering each mode and the any-channel / any-device wildcards
    send_command(mk(OP_WRITE, KIND_CC, 7'd10, 5'd0, 7'd0, 8'd0, 4'd0, MODE_TOGGLE, 8'h11));
    send_command(mk(OP_WRITE, KIND_CC, 7'd10, 5'd16, 7'd0, 8'd255, 4'd1, MODE_MOMENTARY,
                    8'hff));
    send_command(mk(OP_WRITE, KIND_CC, 7'd10, 5'd1, 7'd0, 8'd0, 4'd2, MODE_CONTINUOUS,
                    board.gain_code));
    send_command(mk(OP_WRITE, KIND_CC, 7'd127, 5'd0, 7'd0, 8'd7, 4'd3, MODE_CONTINUOUS,
                    8'h00));
    send_command(mk(OP_WRITE, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd15, MODE_NOTE, 8'h80));
    // toggle rising edge, then held high, then released and pressed again
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd16, 7'd127, 8'd255, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd16, 7'd127, 8'd255, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd1, 7'd0, 8'd3, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd1, 7'd64, 8'd3, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd1, 7'd63, 8'd3, 4'd0, 2'd0, 8'd0));
    // full-scale continuous value, then a device mismatch
    send_command(mk(OP_MIDI, KIND_CC, 7'd127, 5'd5, 7'd127, 8'd7, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd127, 5'd5, 7'd127, 8'd8, 4'd0, 2'd0, 8'd0));
    // note-on fires the note binding; note-off and the spare kind do nothing
    send_command(mk(OP_MIDI, KIND_NOTE_ON, 7'd0, 5'd16, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_NOTE_OFF, 7'd0, 5'd16, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KindSpare, 7'd0, 5'd16, 7'd127, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OpSpare6, KIND_CC, 7'd10, 5'd1, 7'd127, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OpSpare7, KIND_CC, 7'd10, 5'd1, 7'd127, 8'd0, 4'd0, 2'd0, 8'd0));
    // control bindings must not react to a note
    send_command(mk(OP_MIDI, KIND_NOTE_ON, 7'd10, 5'd1, 7'd127, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_REMOVE, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd1, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd16, 7'd127, 8'd255, 4'd0, 2'd0, 8'd0));
    // learn survives a tick, a note-off and the spare kind, then grabs a cc
    send_command(mk(OP_LEARN_START, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_TICK, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_NOTE_OFF, 7'd3, 5'd2, 7'd0, 8'd9, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KindSpare, 7'd3, 5'd2, 7'd0, 8'd9, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd33, 5'd9, 7'd1, 8'd200, 4'd0, 2'd0, 8'd0));
    // restarted learn captures a note; stopped learn leaves matching alone
    send_command(mk(OP_LEARN_START, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_LEARN_START, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_NOTE_ON, 7'd127, 5'd16, 7'd5, 8'd255, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_LEARN_START, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_LEARN_STOP, KIND_CC, 7'd0, 5'd0, 7'd0, 8'd0, 4'd0, 2'd0, 8'd0));
    send_command(mk(OP_MIDI, KIND_CC, 7'd10, 5'd1, 7'd127, 8'd4, 4'd0, 2'd0, 8'd0));
  endtask

  // whole table on one number so a single message can give sixteen results
  task automatic fill_sequence();
    logic [6:0] num;
    command_t   c;
    int         i;
    num = pick_number();
    for (i = 0; i < NumEntries; i++) begin
      c = binding(4'(i), 2'($urandom_range(0, 3)), num);
      if ($urandom_range(0, 3) != 0) begin
        c.channel = 5'd0;
        c.device = 8'd0;
        c.mode = ($urandom_range(0, 1) == 0) ? MODE_MOMENTARY : MODE_CONTINUOUS;
      end
      send_command(c);
    end
    repeat (3) begin
      c = message(($urandom_range(0, 3) == 0) ? KIND_NOTE_ON : KIND_CC);
      c.number = num;
      if ($urandom_range(0, 1) == 0) c.value = 7'd127;
      send_command(c);
    end
  endtask

  task automatic learn_sequence();
    int       span;
    int       k;
    span = (board.timeout_ticks < 8) ? int'(board.timeout_ticks) + 1 : 3;
    send_command(scrambled(OP_LEARN_START));
    if ($urandom_range(0, 4) == 0) send_command(scrambled(OP_LEARN_START));
    k = $urandom_range(0, span);
    repeat (k) send_command(scrambled(OP_TICK));
    if ($urandom_range(0, 3) == 0) send_command(message(KIND_NOTE_OFF));
    if ($urandom_range(0, 5) == 0) send_command(scrambled(OP_LEARN_STOP));
    send_command(message(($urandom_range(0, 1) == 0) ? KIND_NOTE_ON : KIND_CC));
    send_command(message(KIND_CC));
  endtask

  // one toggle binding pushed across the threshold a few times
  task automatic toggle_sequence();
    command_t c;
    logic [6:0] num;
    num = pick_number();
    send_command(binding(4'($urandom_range(0, 15)), MODE_TOGGLE, num));
    repeat (4) begin
      c = message(KIND_CC);
      c.number = num;
      c.value = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 63))
                                           : 7'($urandom_range(64, 127));
      send_command(c);
    end
  endtask

  task automatic noise_command();
    case ($urandom_range(0, 6))
      0: send_command(scrambled(OpSpare6));
      1: send_command(scrambled(OpSpare7));
      2: send_command(message(KindSpare));
      3: send_command(message(KIND_NOTE_OFF));
      4: send_command(scrambled(OP_TICK));
      5: send_command(scrambled(OP_LEARN_STOP));
      default: send_command(scrambled(OP_REMOVE));
    endcase
  endtask

  task automatic random_phase(input int goal);
    int stop_at;
    int pick;
    stop_at = commands_sent + goal;
    fill_sequence();
    while (commands_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) fill_sequence();
      else if (pick < 16) learn_sequence();
      else if (pick < 26) toggle_sequence();
      else if (pick < 34) noise_command();
      else if (pick < 52) send_command(binding(4'($urandom_range(0, 15)),
                                               2'($urandom_range(0, 3)), pick_number()));
      else if (pick < 56) send_command(scrambled(OP_REMOVE));
      else if (pick < 70) send_command(message(KIND_NOTE_ON));
      else send_command(message(KIND_CC));
    end
  endtask

  logic [19:0] phase_timeout [NumPhases];
  logic [7:0]  phase_gain    [NumPhases];
  logic [7:0]  phase_setvol  [NumPhases];

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_MIDI;
    msg_kind = KIND_CC;
    number = '0;
    channel = '0;
    value = '0;
    device_id = '0;
    entry_index = '0;
    bind_mode = MODE_TOGGLE;
    action_code = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_TIMEOUT;
    cfg_wdata = '0;
    // register settings per random phase: extremes first, then random codes
    phase_timeout = '{20'd1, 20'd0, 20'hfffff, 20'd3, 20'd6};
    phase_gain = '{8'd0, 8'd255, 8'd37, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255))};
    phase_setvol = '{8'd255, 8'd0, 8'd200, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))};
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed checks run with the reset register values
    directed_part();
    drain();
    for (int p = 0; p < NumPhases; p++) begin
      set_registers(phase_timeout[p], phase_gain[p], phase_setvol[p]);
      random_phase(PhaseCommands);
      drain();
    end

    $display("covered %0d commands over %0d register settings, %0d results checked",
             commands_sent, NumPhases + 1, board.checked);
    $display("%0d learn captures, %0d messages hit all sixteen bindings",
             board.captures, board.full_hits);
    if (board.failures == 0) begin
      $display("midi_binding_matcher_test passed");
    end else begin
      $display("midi_binding_matcher_test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mbm_pkg.sv
rtl/mbm_table.sv
rtl/mbm_ctrl.sv
rtl/midi_binding_matcher.sv
tb/sv/midi_binding_matcher_test.sv
